@@ hw/rtl/itf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package itf_pkg;

   localparam int unsigned FL_ZERO   = 0;
   localparam int unsigned FL_SIGNED = 1;
   localparam int unsigned FL_PLUS   = 2;
   localparam int unsigned FL_SPACE  = 3;
   localparam int unsigned FL_LEFT   = 4;
   localparam int unsigned FL_PREFIX = 5;
   localparam int unsigned FL_UPPER  = 6;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIZE,
      ST_EMIT,
      ST_OUT
   } state_type;

   // Emission phases, in output order.
   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_PFX,
      PH_ZPAD,
      PH_PREC,
      PH_DIGIT,
      PH_TRAIL,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic load;      // capture the input item and start the division
      logic div_step;  // one quotient bit
      logic size_calc; // work out padding counts
      logic emit_step; // produce one character into the output register
   } cmd_type;

   typedef struct packed {
      logic bad;       // radix outside 2..36
      logic div_done;
      logic emit_done; // last character produced, or nothing to produce
   } sts_type;

   function automatic logic [7:0] digit_char(input logic [5:0] d, input logic upper);
      logic [7:0] c;
      if (d < 6'd10) c = CH_ZERO + {2'b00, d};
      else if (upper) c = 8'h41 + {2'b00, d} - 8'd10;
      else c = 8'h61 + {2'b00, d} - 8'd10;
      if (d > 6'd35) c = CH_ZERO;
      return c;
   endfunction

endpackage

@@ hw/rtl/itf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
module itf_ram #(
   parameter int unsigned WIDTH = 6,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/itf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter controller
// Sequences load, division, sizing and character emission.
// ----------------------------------------------------------------------------
module itf_ctrl
   import itf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.bad) begin
               state_in = ST_SIZE;
            end else if (sts.div_done) begin
               state_in = ST_SIZE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_SIZE: begin
            cmd.size_calc = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            // The RAM read for a digit was issued in the previous cycle.
            cmd.emit_step = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = sts.emit_done ? ST_IDLE : ST_EMIT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/itf_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter datapath
// Restoring radix divider, digit RAM, padding counters and character output.
// ----------------------------------------------------------------------------
module itf_dp
   import itf_pkg::*;
#(
   parameter int unsigned DIGIT_SLOTS = 64,
   parameter int unsigned MAX_ROOM    = 64
) (
   input  logic        clock,
   input  logic [63:0] value,
   input  logic [5:0]  radix,
   input  logic [6:0]  width,
   input  logic [6:0]  min_digits,
   input  logic [6:0]  format_flags,
   input  logic [6:0]  room,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [7:0]  out_char,
   output logic        char_valid,
   output logic        last,
   output logic        bad_radix,
   output logic [7:0]  needed_length
);

   localparam int unsigned AW = $clog2(DIGIT_SLOTS);
   localparam int unsigned CW = $clog2(DIGIT_SLOTS + 1);

   logic [63:0] quo_ff, quo_in;
   logic [5:0]  rem_ff, rem_in;
   logic [6:0]  bit_ff, bit_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [5:0]  rad_ff;
   logic [6:0]  fl_ff;
   logic [6:0]  wid_ff, prec_ff;
   logic [6:0]  room_ff;
   logic [7:0]  sign_ff;
   logic [1:0]  pfx_ff;
   logic        bad_ff;
   logic        nz_ff;
   logic signed [8:0] size_ff;
   logic [7:0]  total_ff;

   phase_type   ph_ff, ph_in;
   logic [7:0]  run_ff, run_in;
   logic [7:0]  ecnt_ff, ecnt_in;
   logic [7:0]  limit_ff;
   logic [CW-1:0] dptr_ff, dptr_in;

   logic [7:0]  och_ff, och_in;
   logic        ocv_ff, ocv_in, olast_ff, olast_in, obad_ff, obad_in;
   logic [7:0]  olen_ff, olen_in;

   logic [5:0]  rd_data;
   logic [AW-1:0] rd_addr;
   logic [6:0]  trial;
   logic        ge;
   logic [5:0]  rem_nx;
   logic        wr_en;

   // Input decode: flags and sign.
   logic [6:0] fl_eff;
   logic       neg;
   always_comb begin
      fl_eff = format_flags;
      if (format_flags[FL_LEFT]) fl_eff[FL_ZERO] = 1'b0;
      neg = fl_eff[FL_SIGNED] && value[63];
   end

   // One restoring division bit.
   assign trial  = {rem_ff, quo_ff[63]};
   assign ge     = trial >= {1'b0, rad_ff};
   assign rem_nx = ge ? 6'(trial - {1'b0, rad_ff}) : trial[5:0];
   assign wr_en  = cmd.div_step && (bit_ff == 7'd63) && (cnt_ff < CW'(DIGIT_SLOTS));

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         quo_in = neg ? 64'(0 - value) : value;
         bit_in = '0;
         cnt_in = '0;
         rem_in = '0;
      end else if (cmd.div_step) begin
         rem_in = rem_nx;
         quo_in = {quo_ff[62:0], ge};
         if (bit_ff == 7'd63) begin
            bit_in = '0;
            if (cnt_ff < CW'(DIGIT_SLOTS)) cnt_in = cnt_ff + 1'b1;
            rem_in = '0;
         end else begin
            bit_in = bit_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      // Marks that a full digit pass has run; the value is zero-tested after.
      if (cmd.load) nz_ff <= 1'b0;
      else if (cmd.div_step && bit_ff == 7'd63) nz_ff <= 1'b1;
   end

   // Sizing.
   logic [6:0] n7, p7;
   logic signed [8:0] size_c;
   logic [8:0] tot_c;
   logic [8:0] sgn_len;
   always_comb begin
      n7      = 7'(cnt_ff);
      p7      = (prec_ff < n7) ? n7 : prec_ff;
      sgn_len = (sign_ff != 8'd0) ? 9'd1 : 9'd0;
      size_c  = $signed({2'b00, wid_ff}) - $signed(sgn_len) - $signed({7'd0, pfx_ff})
              - $signed({2'b00, p7});
      tot_c   = sgn_len + {7'd0, pfx_ff} + {2'b00, p7}
              + ((size_c > 0) ? 9'(size_c) : 9'd0);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rad_ff  <= radix;
         fl_ff   <= fl_eff;
         wid_ff  <= width;
         prec_ff <= min_digits;
         room_ff <= (room > 7'(MAX_ROOM)) ? 7'(MAX_ROOM) : room;
         bad_ff  <= (radix < 6'd2) || (radix > 6'd36);
         if (neg) sign_ff <= CH_MINUS;
         else if (fl_eff[FL_SIGNED] && fl_eff[FL_PLUS]) sign_ff <= CH_PLUS;
         else if (fl_eff[FL_SIGNED] && fl_eff[FL_SPACE]) sign_ff <= CH_SPACE;
         else sign_ff <= 8'd0;
         if (fl_eff[FL_PREFIX] && radix == 6'd16) pfx_ff <= 2'd2;
         else if (fl_eff[FL_PREFIX] && radix == 6'd8) pfx_ff <= 2'd1;
         else pfx_ff <= 2'd0;
      end else if (cmd.size_calc) begin
         prec_ff <= p7;
      end
   end

   assign sts.bad       = bad_ff;
   assign sts.div_done  = nz_ff && (bit_ff == 7'd0) && (quo_ff == 64'd0);
   assign sts.emit_done = olast_ff;

   always_ff @(posedge clock) begin
      if (cmd.size_calc) begin
         size_ff  <= size_c;
         total_ff <= tot_c[7:0];
         limit_ff <= ({1'b0, room_ff} < tot_c[7:0]) ? {1'b0, room_ff} : tot_c[7:0];
      end
   end

   // Emission: walk the phases, skipping empty ones.
   logic [7:0] pad;
   logic       upper;
   logic [7:0] ch;
   assign pad   = (size_ff > 0) ? size_ff[7:0] : 8'd0;
   assign upper = fl_ff[FL_UPPER];

   function automatic logic [7:0] phase_len(input phase_type p, input logic [7:0] pd,
                                            input logic [6:0] fl, input logic [7:0] sg,
                                            input logic [1:0] pf, input logic [7:0] pz,
                                            input logic [7:0] nd);
      logic [7:0] l;
      case (p)
         PH_LEAD:  l = (!fl[FL_ZERO] && !fl[FL_LEFT]) ? pd : 8'd0;
         PH_SIGN:  l = (sg != 8'd0) ? 8'd1 : 8'd0;
         PH_PFX:   l = {6'd0, pf};
         PH_ZPAD:  l = fl[FL_ZERO] ? pd : 8'd0;
         PH_PREC:  l = pz;
         PH_DIGIT: l = nd;
         PH_TRAIL: l = fl[FL_LEFT] ? pd : 8'd0;
         default:  l = 8'd1;
      endcase
      return l;
   endfunction

   logic [7:0] nd8, pz8;
   assign nd8 = 8'(cnt_ff);
   assign pz8 = {1'b0, prec_ff} - nd8;

   // Next non-empty phase after the given one.
   function automatic phase_type next_ph(input phase_type p, input logic [7:0] pd,
                                         input logic [6:0] fl, input logic [7:0] sg,
                                         input logic [1:0] pf, input logic [7:0] pz,
                                         input logic [7:0] nd);
      phase_type q;
      q = p;
      for (int i = 0; i < 7; i++) begin
         if (q != PH_DONE && (q == p || phase_len(q, pd, fl, sg, pf, pz, nd) == 8'd0))
            q = phase_type'(q + 3'd1);
      end
      return q;
   endfunction

   phase_type ph_cur, ph_nx;
   always_comb begin
      ph_in   = ph_ff;
      run_in  = run_ff;
      ecnt_in = ecnt_ff;
      dptr_in = dptr_ff;
      och_in  = och_ff;
      ocv_in  = ocv_ff;
      olast_in = olast_ff;
      obad_in = obad_ff;
      olen_in = olen_ff;
      ch      = CH_SPACE;
      ph_cur  = ph_ff;
      ph_nx   = ph_ff;
      if (cmd.size_calc) begin
         // First phase, which may be empty.
         ph_in   = PH_LEAD;
         run_in  = 8'd0;
         ecnt_in = 8'd0;
         dptr_in = cnt_ff - 1'b1;
      end else if (cmd.emit_step) begin
         // Skip an empty first phase here.
         ph_cur = ph_ff;
         if (run_ff == 8'd0 && phase_len(ph_ff, pad, fl_ff, sign_ff, pfx_ff, pz8, nd8) == 8'd0)
            ph_cur = next_ph(ph_ff, pad, fl_ff, sign_ff, pfx_ff, pz8, nd8);
         case (ph_cur)
            PH_LEAD:  ch = CH_SPACE;
            PH_SIGN:  ch = sign_ff;
            PH_PFX:   ch = (run_ff == 8'd0) ? CH_ZERO : (upper ? 8'h58 : 8'h78);
            PH_ZPAD:  ch = CH_ZERO;
            PH_PREC:  ch = CH_ZERO;
            PH_DIGIT: ch = digit_char(rd_data, upper);
            PH_TRAIL: ch = CH_SPACE;
            default:  ch = CH_SPACE;
         endcase
         if (ph_cur == PH_DIGIT) dptr_in = dptr_ff - 1'b1;
         if (run_ff + 8'd1 >= phase_len(ph_cur, pad, fl_ff, sign_ff, pfx_ff, pz8, nd8)) begin
            ph_nx  = next_ph(ph_cur, pad, fl_ff, sign_ff, pfx_ff, pz8, nd8);
            run_in = 8'd0;
            ph_in  = ph_nx;
         end else begin
            run_in = run_ff + 8'd1;
            ph_in  = ph_cur;
         end
         ecnt_in = ecnt_ff + 8'd1;
         if (bad_ff) begin
            och_in = 8'd0; ocv_in = 1'b0; olast_in = 1'b1; obad_in = 1'b1; olen_in = 8'd0;
         end else if (limit_ff == 8'd0) begin
            och_in = 8'd0; ocv_in = 1'b0; olast_in = 1'b1; obad_in = 1'b0;
            olen_in = total_ff;
         end else begin
            och_in   = ch;
            ocv_in   = 1'b1;
            obad_in  = 1'b0;
            olast_in = (ecnt_in == limit_ff);
            olen_in  = olast_in ? total_ff : 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ph_ff    <= ph_in;
      run_ff   <= run_in;
      ecnt_ff  <= ecnt_in;
      dptr_ff  <= dptr_in;
      och_ff   <= och_in;
      ocv_ff   <= ocv_in;
      olast_ff <= olast_in;
      obad_ff  <= obad_in;
      olen_ff  <= olen_in;
   end

   assign out_char      = och_ff;
   assign char_valid    = ocv_ff;
   assign last          = olast_ff;
   assign bad_radix     = obad_ff;
   assign needed_length = olen_ff;

   // The next digit pointer is read ahead, so its data is ready at the following emit.
   assign rd_addr = dptr_in[AW-1:0];

   itf_ram #(
      .WIDTH (6),
      .DEPTH (DIGIT_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (rem_nx),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

@@ hw/rtl/integer_to_text_formatter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter
// printf-style integer to ASCII conversion, one character per transfer.
// ----------------------------------------------------------------------------
// Sequence: after an item is accepted, the restoring divider produces one
// quotient bit a cycle, one full pass per digit; sizing and emission follow,
// and each character is held until the receiver is ready to take it.
// A new item is accepted only once the last character of the previous one
// has been taken; the shared bit-serial divider serves every digit.
// Reset: synchronous, active high; clears the controller to idle.
module integer_to_text_formatter_top
   import itf_pkg::*;
#(
   parameter int unsigned DIGIT_SLOTS = 64,
   parameter int unsigned MAX_ROOM    = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // value[63:0], radix[69:64], width[76:70], min_digits[83:77],
   // format_flags[90:84], room[97:91], zero fill to 104 bits
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_char[7:0], needed_length[15:8]
   output logic [15:0]  rsp_tdata,
   // char_valid[0], bad_radix[1]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   itf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   itf_dp #(
      .DIGIT_SLOTS (DIGIT_SLOTS),
      .MAX_ROOM    (MAX_ROOM)
   ) u_dp (
      .clock         (clock),
      .value         (req_tdata[63:0]),
      .radix         (req_tdata[69:64]),
      .width         (req_tdata[76:70]),
      .min_digits    (req_tdata[83:77]),
      .format_flags  (req_tdata[90:84]),
      .room          (req_tdata[97:91]),
      .cmd           (cmd),
      .sts           (sts),
      .out_char      (rsp_tdata[7:0]),
      .char_valid    (rsp_tuser[0]),
      .last          (rsp_tlast),
      .bad_radix     (rsp_tuser[1]),
      .needed_length (rsp_tdata[15:8])
   );

endmodule
